/* hdl/epc_pkg.sv */
// ----------------------------------------------------------------------------
// Escape phrase converter package
// Shared types, phrase table and helper functions for the converter core.
// ----------------------------------------------------------------------------
package epc_pkg;

	// Sizes
	localparam int CHAR_W          = 8;
	localparam int BUF_DEPTH       = 6;	// held prefix (up to 5) plus the new character
	localparam int BUF_IDX_W       = 3;
	localparam int MAX_LONG        = 6;
	localparam int PHRASE_COUNT    = 15;
	localparam int CLASS_COUNT     = 12;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = CLASS_COUNT;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_MASK   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONDENSE_MASK = 1'b1;

	typedef logic [CHAR_W-1:0]             char_t;
	typedef logic [BUF_IDX_W-1:0]          pos_t;
	typedef logic [CLASS_COUNT-1:0]        class_mask_t;
	typedef logic [MAX_LONG-1:0][CHAR_W-1:0] long_str_t;

	// Phrase table entries, in match priority order
	typedef enum logic [3:0] {
		PH_NEWLINE,
		PH_APOS,
		PH_AMP,
		PH_GT,
		PH_LT,
		PH_QUOT,
		PH_PERCENT,
		PH_PLUS,
		PH_SQ_OPEN,
		PH_SQ_CLOSE,
		PH_CU_OPEN,
		PH_CU_CLOSE,
		PH_RO_OPEN,
		PH_RO_CLOSE,
		PH_TAB,
		PH_NONE
	} phrase_t;

	// Classes: bit positions in the mask registers
	typedef enum logic [3:0] {
		CLS_NEWLINE,
		CLS_APOS,
		CLS_AMP,
		CLS_GT,
		CLS_LT,
		CLS_QUOT,
		CLS_PERCENT,
		CLS_PLUS,
		CLS_SQUARE,
		CLS_CURLY,
		CLS_ROUND,
		CLS_TAB
	} cls_t;

	// Scanner states
	typedef enum logic [1:0] {
		ST_WAIT,	// waiting for the next character from the queue
		ST_SCAN,	// one phrase decision per cycle unless the output stalls
		ST_EMIT		// sending the rest of a long form
	} back_state_t;

	// Channel payloads
	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              end_of_string;
	} epc_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              run_end;
		logic              string_end;
		logic              converted;
	} epc_out_t;

	// Classified character travelling through the queue
	typedef struct packed {
		char_t   ch;
		logic    eos;
		phrase_t short_ph;
	} epc_item_t;

	// Mask registers handed to the scanner
	typedef struct packed {
		class_mask_t expand_mask;
		class_mask_t condense_mask;
	} epc_cfg_t;

	// Short form of each phrase
	function automatic char_t short_char(input phrase_t ph);
		char_t c;
		c = '0;
		unique case (ph)
			PH_NEWLINE:  c = 8'h0A;
			PH_APOS:     c = 8'h27;
			PH_AMP:      c = 8'h26;
			PH_GT:       c = 8'h3E;
			PH_LT:       c = 8'h3C;
			PH_QUOT:     c = 8'h22;
			PH_PERCENT:  c = 8'h25;
			PH_PLUS:     c = 8'h2B;
			PH_SQ_OPEN:  c = 8'h5B;
			PH_SQ_CLOSE: c = 8'h5D;
			PH_CU_OPEN:  c = 8'h7B;
			PH_CU_CLOSE: c = 8'h7D;
			PH_RO_OPEN:  c = 8'h28;
			PH_RO_CLOSE: c = 8'h29;
			PH_TAB:      c = 8'h09;
			PH_NONE:     c = '0;
		endcase
		return c;
	endfunction

	// Long form length
	function automatic pos_t long_len(input phrase_t ph);
		pos_t n;
		n = 3'd1;
		unique case (ph)
			PH_NEWLINE, PH_SQ_OPEN, PH_SQ_CLOSE, PH_CU_OPEN, PH_CU_CLOSE,
			PH_RO_OPEN, PH_RO_CLOSE, PH_TAB: n = 3'd2;
			PH_APOS, PH_PERCENT, PH_NONE:     n = 3'd1;
			PH_AMP:                           n = 3'd5;
			PH_GT, PH_LT, PH_PLUS:            n = 3'd4;
			PH_QUOT:                          n = 3'd6;
		endcase
		return n;
	endfunction

	// Long form text, element 0 is the first character
	function automatic long_str_t long_str(input phrase_t ph);
		long_str_t s;
		s = '0;
		unique case (ph)
			PH_NEWLINE:  begin s[0] = 8'h5C; s[1] = 8'h6E; end	// \n
			PH_APOS:     begin s[0] = 8'h60; end			// backtick
			PH_AMP:      begin
				s[0] = 8'h26; s[1] = 8'h61; s[2] = 8'h6D; s[3] = 8'h70; s[4] = 8'h3B;
			end
			PH_GT:       begin s[0] = 8'h26; s[1] = 8'h67; s[2] = 8'h74; s[3] = 8'h3B; end
			PH_LT:       begin s[0] = 8'h26; s[1] = 8'h6C; s[2] = 8'h74; s[3] = 8'h3B; end
			PH_QUOT:     begin
				s[0] = 8'h26; s[1] = 8'h71; s[2] = 8'h75;
				s[3] = 8'h6F; s[4] = 8'h74; s[5] = 8'h3B;
			end
			PH_PERCENT:  begin s[0] = 8'hB6; end			// pilcrow
			PH_PLUS:     begin s[0] = 8'h5C; s[1] = 8'h30; s[2] = 8'h35; s[3] = 8'h33; end
			PH_SQ_OPEN:  begin s[0] = 8'h5C; s[1] = 8'h5B; end
			PH_SQ_CLOSE: begin s[0] = 8'h5C; s[1] = 8'h5D; end
			PH_CU_OPEN:  begin s[0] = 8'h5C; s[1] = 8'h7B; end
			PH_CU_CLOSE: begin s[0] = 8'h5C; s[1] = 8'h7D; end
			PH_RO_OPEN:  begin s[0] = 8'h5C; s[1] = 8'h28; end
			PH_RO_CLOSE: begin s[0] = 8'h5C; s[1] = 8'h29; end
			PH_TAB:      begin s[0] = 8'h5C; s[1] = 8'h74; end	// \t
			PH_NONE:     s = '0;
		endcase
		return s;
	endfunction

	// Mask bit of each phrase
	function automatic cls_t phrase_cls(input phrase_t ph);
		cls_t c;
		c = CLS_NEWLINE;
		unique case (ph)
			PH_NEWLINE:               c = CLS_NEWLINE;
			PH_APOS:                  c = CLS_APOS;
			PH_AMP:                   c = CLS_AMP;
			PH_GT:                    c = CLS_GT;
			PH_LT:                    c = CLS_LT;
			PH_QUOT:                  c = CLS_QUOT;
			PH_PERCENT:               c = CLS_PERCENT;
			PH_PLUS:                  c = CLS_PLUS;
			PH_SQ_OPEN, PH_SQ_CLOSE:  c = CLS_SQUARE;
			PH_CU_OPEN, PH_CU_CLOSE:  c = CLS_CURLY;
			PH_RO_OPEN, PH_RO_CLOSE:  c = CLS_ROUND;
			PH_TAB, PH_NONE:          c = CLS_TAB;
		endcase
		return c;
	endfunction

	// Which phrase a character is the short form of, if any
	function automatic phrase_t short_lookup(input char_t ch);
		phrase_t ph;
		ph = PH_NONE;
		for (int i = PHRASE_COUNT - 1; i >= 0; i--) begin
			if (ch == short_char(phrase_t'(4'(i))))
				ph = phrase_t'(4'(i));
		end
		return ph;
	endfunction

endpackage

/* hdl/epc_front.sv */
// ----------------------------------------------------------------------------
// Escape phrase converter front end
// Accepts input transactions, tags each character with its short-form phrase
// and hands it to the queue through one register stage.
// ----------------------------------------------------------------------------
module epc_front
	import epc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  epc_in_t   in_data,
	output logic      push_valid,
	input  logic      push_ready,
	output epc_item_t push_item
);

	logic      valid_s1;
	epc_item_t item_s1;

	// Hold while the staged item cannot move on
	assign in_stall   = valid_s1 && !push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Classified payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.ch       <= in_data.in_char;
			item_s1.eos      <= in_data.end_of_string;
			item_s1.short_ph <= short_lookup(in_data.in_char);
		end
	end

endmodule

/* hdl/epc_queue.sv */
// ----------------------------------------------------------------------------
// Escape phrase converter queue
// Small FIFO of classified characters between front end and scanner.
// ----------------------------------------------------------------------------
module epc_queue
	import epc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  epc_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output epc_item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	epc_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_ready && pop_valid;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

/* hdl/epc_back.sv */
// ----------------------------------------------------------------------------
// Escape phrase converter scanner
// Keeps the held prefix, decides one phrase per cycle unless stalled, sends
// the resulting characters and marks the last one of each input transaction.
// ----------------------------------------------------------------------------
module epc_back
	import epc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  epc_cfg_t  cfg,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  epc_item_t pop_item,
	output logic      out_valid,
	input  logic      out_stall,
	output epc_out_t  out_data
);

	back_state_t state_q, state_d;

	// Character buffer: held prefix plus newest character
	char_t   hold_ch_q [BUF_DEPTH];
	phrase_t hold_sh_q [BUF_DEPTH];
	pos_t    n_q;
	pos_t    p_q;
	logic    final_q;
	logic    any_q;

	// Long form being sent
	phrase_t seq_ph_q;
	pos_t    seq_pos_q;

	// One character kept back so the last one of a transaction can be marked
	logic    pend_v_q;
	char_t   pend_ch_q;

	logic     out_v_q;
	epc_out_t out_q;

	// Scan window at the current position
	pos_t    rem;
	char_t   win_ch [BUF_DEPTH];
	phrase_t win_sh [BUF_DEPTH];
	logic    hit_found;
	phrase_t hit_ph;
	logic    wait_more;

	// Decision
	logic    stop;
	logic    dec_long;
	phrase_t dec_ph;
	char_t   dec_char;
	pos_t    dec_adv;
	logic    dec_repl;
	logic    dec_multi;

	// Control
	logic    can_emit;
	logic    emit_now;
	char_t   emit_char;
	logic    end_step;
	logic    take;
	logic    emit_last;

	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign rem       = n_q - p_q;

	// Window extraction
	always_comb begin
		logic [BUF_IDX_W:0] widx;
		widx = '0;
		for (int j = 0; j < BUF_DEPTH; j++) begin
			widx = {1'b0, p_q} + (BUF_IDX_W + 1)'(j);
			if (widx < (BUF_IDX_W + 1)'(BUF_DEPTH)) begin
				win_ch[j] = hold_ch_q[widx[BUF_IDX_W-1:0]];
				win_sh[j] = hold_sh_q[widx[BUF_IDX_W-1:0]];
			end else begin
				win_ch[j] = '0;
				win_sh[j] = PH_NONE;
			end
		end
	end

	// Long form matching: first full match wins, else a partial match waits
	always_comb begin
		long_str_t str;
		pos_t      len;
		logic      pm;
		hit_found = 1'b0;
		hit_ph    = PH_NONE;
		wait_more = 1'b0;
		for (int i = 0; i < PHRASE_COUNT; i++) begin
			str = long_str(phrase_t'(4'(i)));
			len = long_len(phrase_t'(4'(i)));
			pm  = 1'b1;
			for (int j = 0; j < MAX_LONG; j++) begin
				if (3'(j) < len && 3'(j) < rem && win_ch[j] != str[j])
					pm = 1'b0;
			end
			if (rem >= len) begin
				if (pm && !hit_found) begin
					hit_found = 1'b1;
					hit_ph    = phrase_t'(4'(i));
				end
			end else if (!final_q && pm) begin
				wait_more = 1'b1;
			end
		end
	end

	// What to send for the current position
	always_comb begin
		stop     = (p_q == n_q) || (!hit_found && wait_more);
		dec_long = 1'b0;
		dec_ph   = PH_NONE;
		dec_char = win_ch[0];
		dec_adv  = 3'd1;
		dec_repl = 1'b0;
		priority if (hit_found) begin
			dec_adv = long_len(hit_ph);
			if (cfg.condense_mask[phrase_cls(hit_ph)]) begin
				dec_char = short_char(hit_ph);
				dec_repl = 1'b1;
			end else begin
				dec_long = 1'b1;
				dec_ph   = hit_ph;
			end
		end else if (win_sh[0] != PH_NONE && cfg.expand_mask[phrase_cls(win_sh[0])]) begin
			dec_long = 1'b1;
			dec_ph   = win_sh[0];
			dec_repl = 1'b1;
		end else begin
			dec_char = win_ch[0];
		end
		dec_multi = dec_long && (long_len(dec_ph) > 3'd1);
	end

	// Handshake-level control
	always_comb begin
		long_str_t dec_text;
		long_str_t seq_text;
		dec_text  = long_str(dec_ph);
		seq_text  = long_str(seq_ph_q);
		can_emit  = !pend_v_q || !out_v_q || !out_stall;
		emit_last = (seq_pos_q == long_len(seq_ph_q) - 3'd1);
		emit_now  = 1'b0;
		emit_char = '0;
		end_step  = 1'b0;
		unique case (state_q)
			ST_WAIT: begin
			end
			ST_SCAN: begin
				emit_now  = !stop && can_emit;
				emit_char = dec_long ? dec_text[0] : dec_char;
				end_step  = stop && can_emit;
			end
			ST_EMIT: begin
				emit_now  = can_emit;
				emit_char = seq_text[seq_pos_q];
			end
			default: begin
			end
		endcase
		take      = pop_valid && ((state_q == ST_WAIT) || end_step);
		pop_ready = take;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_WAIT: begin
				if (take)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (end_step)
					state_d = take ? ST_SCAN : ST_WAIT;
				else if (emit_now && dec_multi)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_now && emit_last)
					state_d = ST_SCAN;
			end
			default: state_d = ST_WAIT;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WAIT;
			n_q      <= '0;
			p_q      <= '0;
			final_q  <= 1'b0;
			any_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// Position, buffer fill and string flags
			if (end_step || take) begin
				n_q <= take ? rem + 3'd1 : rem;
				p_q <= '0;
			end else if (state_q == ST_SCAN && emit_now) begin
				p_q <= p_q + dec_adv;
			end
			if (take)
				final_q <= pop_item.eos;

			if (state_q == ST_SCAN && emit_now && dec_repl)
				any_q <= 1'b1;
			else if (end_step && final_q)
				any_q <= 1'b0;

			// Pending character
			if (emit_now)
				pend_v_q <= 1'b1;
			else if (end_step)
				pend_v_q <= 1'b0;

			// Output register
			if (pend_v_q && (emit_now || end_step))
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		// Compact the buffer to the unresolved tail and append the next character
		if (end_step || take) begin
			for (int j = 0; j < BUF_DEPTH; j++) begin
				if (take && 3'(j) == rem) begin
					hold_ch_q[j] <= pop_item.ch;
					hold_sh_q[j] <= pop_item.short_ph;
				end else begin
					hold_ch_q[j] <= win_ch[j];
					hold_sh_q[j] <= win_sh[j];
				end
			end
		end

		// Long form progress
		if (state_q == ST_SCAN && emit_now) begin
			seq_ph_q  <= dec_ph;
			seq_pos_q <= 3'd1;
		end else if (state_q == ST_EMIT && emit_now) begin
			seq_pos_q <= seq_pos_q + 3'd1;
		end

		if (emit_now)
			pend_ch_q <= emit_char;

		if (pend_v_q && (emit_now || end_step)) begin
			out_q.out_char   <= pend_ch_q;
			out_q.run_end    <= end_step;
			out_q.string_end <= end_step && final_q;
			out_q.converted  <= end_step && final_q && any_q;
		end
	end

endmodule

/* hdl/escape_phrase_converter_core.sv */
// ----------------------------------------------------------------------------
// Escape phrase converter core
// Converts XML entities, backslash escapes and related phrases in a stream.
// ----------------------------------------------------------------------------
// Characters enter one per transaction, are tagged in a front stage and wait
// in a short queue; the scanner resolves one phrase per cycle, which sets the
// throughput, and sends one output character per cycle unless out_stall holds
// it. A plain character is sent, then its transaction closes and the next is
// taken from the queue; further characters of a long form follow in the emit
// state, and a phrase is decided again after a failed prefix. Up to five
// characters that may start a long form are held back and yield no output
// until the phrase is decided or the string ends. run_end marks the last
// character caused by an input transaction; string_end comes with the final
// one of a string, and converted too if a phrase was replaced. The user must
// write the mask registers via the cfg port only while idle (not enforced).
// ----------------------------------------------------------------------------
module escape_phrase_converter_core
	import epc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  epc_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output epc_out_t              out_data
);

	epc_cfg_t  cfg_q;
	logic      push_valid;
	logic      push_ready;
	epc_item_t push_item;
	logic      pop_valid;
	logic      pop_ready;
	epc_item_t pop_item;

	// Mask registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_EXPAND_MASK:   cfg_q.expand_mask   <= cfg_wdata;
				CFG_CONDENSE_MASK: cfg_q.condense_mask <= cfg_wdata;
			endcase
		end
	end

	epc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	epc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	epc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
